[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/dhfk_pkg.sv]
// Shared types and constants for the DH chain forward kinematics unit.
// No dependencies.
package dhfk_pkg;

	localparam int CordicSteps = 30;
	localparam logic signed [33:0] CordicGain = 34'sd652032874;

	// Back-end sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CORDIC,
		ST_LINK,
		ST_MAT,
		ST_OUT
	} be_state_t;

	// Arctangent table, binary angle steps in Q0.32 turns.
	function automatic logic signed [33:0] atan_lut(input logic [4:0] i);
		logic signed [33:0] r;
		unique case (i)
			5'd0: r = 34'sh20000000; 5'd1: r = 34'sh12E4051E;
			5'd2: r = 34'sh09FB385B; 5'd3: r = 34'sh051111D4;
			5'd4: r = 34'sh028B0D43; 5'd5: r = 34'sh0145D7E1;
			5'd6: r = 34'sh00A2F61E; 5'd7: r = 34'sh00517C55;
			5'd8: r = 34'sh0028BE53; 5'd9: r = 34'sh00145F2F;
			5'd10: r = 34'sh000A2F98; 5'd11: r = 34'sh000517CC;
			5'd12: r = 34'sh00028BE6; 5'd13: r = 34'sh000145F3;
			5'd14: r = 34'sh0000A2FA; 5'd15: r = 34'sh0000517D;
			5'd16: r = 34'sh000028BE; 5'd17: r = 34'sh0000145F;
			5'd18: r = 34'sh00000A30; 5'd19: r = 34'sh00000518;
			5'd20: r = 34'sh0000028C; 5'd21: r = 34'sh00000146;
			5'd22: r = 34'sh000000A3; 5'd23: r = 34'sh00000051;
			5'd24: r = 34'sh00000029; 5'd25: r = 34'sh00000014;
			5'd26: r = 34'sh0000000A; 5'd27: r = 34'sh00000005;
			5'd28: r = 34'sh00000003; 5'd29: r = 34'sh00000001;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

[hw/rtl/dhfk_if.sv]
// Valid/ready channel interfaces for link items and frame results.
// Depends on nothing.
interface dhfk_link_if #(
	parameter int AngleBits = 16
);
	logic                  valid;
	logic                  ready;
	logic                  restart_chain;
	logic signed [31:0]    link_offset_a;
	logic [AngleBits-1:0]  link_twist;
	logic signed [31:0]    link_offset_d;
	logic [AngleBits-1:0]  joint_angle;

	modport source (output valid, restart_chain, link_offset_a, link_twist,
		link_offset_d, joint_angle, input ready);
	modport sink (input valid, restart_chain, link_offset_a, link_twist,
		link_offset_d, joint_angle, output ready);
endinterface

interface dhfk_frame_if;
	logic               valid;
	logic               ready;
	logic signed [17:0] rot_00, rot_01, rot_02;
	logic signed [17:0] rot_10, rot_11, rot_12;
	logic signed [17:0] rot_20, rot_21, rot_22;
	logic signed [31:0] pos_x, pos_y, pos_z;

	modport source (output valid, rot_00, rot_01, rot_02, rot_10, rot_11, rot_12,
		rot_20, rot_21, rot_22, pos_x, pos_y, pos_z, input ready);
	modport sink (input valid, rot_00, rot_01, rot_02, rot_10, rot_11, rot_12,
		rot_20, rot_21, rot_22, pos_x, pos_y, pos_z, output ready);
endinterface

[hw/rtl/dh_chain_forward_kinematics_unit.sv]
// Top level of the modified-DH forward kinematics unit.
// Depends on dhfk_pkg, dhfk_if, dhfk_front and dhfk_back.
//
//  channel  role   beat content
//  link     sink   restart flag, a, alpha, d, theta
//  frame    source rotation 3x3 and position 3
//
// Each link passes through a start state, two 30-step CORDIC runs, six
// transform multiplies, 36 frame multiplies on one shared multiplier, and
// an output state.
// A two-entry queue takes new links while the back end works.
// Reset sets the frame to identity; the result beat holds until taken.
module dh_chain_forward_kinematics_unit #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16,
	parameter int ANGLE_BITS = 16
) (
	input logic          clk,
	input logic          arst_n,
	dhfk_link_if.sink    link,
	dhfk_frame_if.source frame
);
	import dhfk_pkg::*;

	logic q_valid, q_restart, pop;
	logic signed [DATA_WIDTH-1:0] q_a, q_d;
	logic [ANGLE_BITS-1:0] q_twist, q_theta;

	dhfk_front #(.DataWidth(DATA_WIDTH), .AngleBits(ANGLE_BITS)) u_front (
		.clk, .arst_n, .link, .pop, .q_valid, .q_restart, .q_a, .q_d, .q_twist, .q_theta
	);

	dhfk_back #(.DataWidth(DATA_WIDTH), .FracBits(FRAC_BITS), .AngleBits(ANGLE_BITS))
	u_back (
		.clk, .arst_n, .q_valid, .q_restart, .q_a, .q_d, .q_twist, .q_theta, .pop,
		.res(frame)
	);
endmodule

[hw/rtl/dhfk_front.sv]
// Front end: accepts links, saturates offsets and queues them.
// Depends on dhfk_pkg and dhfk_link_if.
module dhfk_front #(
	parameter int DataWidth = 32,
	parameter int AngleBits = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	dhfk_link_if.sink                   link,
	input  logic                        pop,
	output logic                        q_valid,
	output logic                        q_restart,
	output logic signed [DataWidth-1:0] q_a,
	output logic signed [DataWidth-1:0] q_d,
	output logic [AngleBits-1:0]        q_twist,
	output logic [AngleBits-1:0]        q_theta
);
	import dhfk_pkg::*;

	localparam int EntW = 1 + 2 * DataWidth + 2 * AngleBits;

	logic [EntW-1:0] ent_q [2];
	logic            wp_q, rp_q;
	logic [1:0]      cnt_q;
	logic            push;
	logic signed [DataWidth-1:0] a_sat, d_sat;

	// Saturate a 32-bit signed offset to the datapath width.
	function automatic logic signed [DataWidth-1:0] sat_in(input logic signed [31:0] v);
		logic signed [63:0] w;
		logic signed [63:0] hi, lo;
		w  = 64'(v);
		hi = (64'sd1 <<< (DataWidth - 1)) - 64'sd1;
		lo = -hi - 64'sd1;
		if (w > hi) w = hi;
		else if (w < lo) w = lo;
		return w[DataWidth-1:0];
	endfunction

	assign a_sat      = sat_in(link.link_offset_a);
	assign d_sat      = sat_in(link.link_offset_d);
	assign link.ready = (cnt_q != 2'd2);
	assign push       = link.valid && link.ready;
	assign q_valid    = (cnt_q != 2'd0);
	assign {q_restart, q_a, q_d, q_twist, q_theta} = ent_q[rp_q];

	// Advance the two-entry queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	// Store a link entry.
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= {link.restart_chain, a_sat, d_sat, link.link_twist,
				link.joint_angle};
		end
	end
endmodule

[hw/rtl/dhfk_cordic.sv]
// Iterative rotation CORDIC, one step per cycle, giving sine and cosine.
// Depends on dhfk_pkg.
module dhfk_cordic #(
	parameter int AngleBits = 16,
	parameter int FracBits  = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [AngleBits-1:0]      angle,
	output logic                      done,
	output logic signed [FracBits+1:0] sin_o,
	output logic signed [FracBits+1:0] cos_o
);
	import dhfk_pkg::*;

	logic signed [33:0] x_q, y_q, z_q;
	logic [1:0]         quad_q;
	logic [4:0]         it_q;
	logic               busy_q;
	logic [31:0]        a32, zr;
	logic [1:0]         quad;
	logic signed [33:0] xs, ys;
	logic signed [FracBits+1:0] cs, sn;

	assign a32  = {angle, {(32 - AngleBits){1'b0}}};
	assign quad = 2'((a32 + 32'h2000_0000) >> 30);
	assign zr   = a32 - {quad, 30'd0};
	assign xs   = x_q >>> it_q;
	assign ys   = y_q >>> it_q;

	// Round Q2.30 to the output fraction and clamp to unit range.
	function automatic logic signed [FracBits+1:0] to_frac(input logic signed [33:0] v);
		logic signed [33:0] r;
		logic signed [33:0] one;
		one = 34'sd1 <<< FracBits;
		if (FracBits == 30) r = v;
		else r = (v + (34'sd1 <<< (29 - FracBits))) >>> (30 - FracBits);
		if (r > one) r = one;
		else if (r < -one) r = -one;
		return r[FracBits+1:0];
	endfunction

	// Run iterations.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			it_q   <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				it_q   <= '0;
			end else if (busy_q) begin
				if (it_q == 5'(CordicSteps - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
				it_q <= it_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= CordicGain;
			y_q    <= '0;
			z_q    <= 34'(signed'(zr));
			quad_q <= quad;
		end else if (busy_q) begin
			if (!z_q[33]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_lut(it_q);
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_lut(it_q);
			end
		end
	end

	assign cs = to_frac(x_q);
	assign sn = to_frac(y_q);

	// Fold the quadrant back in.
	always_comb begin
		unique case (quad_q)
			2'd0: begin cos_o = cs; sin_o = sn; end
			2'd1: begin cos_o = -sn; sin_o = cs; end
			2'd2: begin cos_o = -cs; sin_o = -sn; end
			default: begin cos_o = sn; sin_o = -cs; end
		endcase
	end
endmodule

[hw/rtl/dhfk_back.sv]
// Back end: sine/cosine, link transform and frame product on one multiplier.
// Depends on dhfk_pkg and dhfk_cordic.
module dhfk_back #(
	parameter int DataWidth = 32,
	parameter int FracBits  = 16,
	parameter int AngleBits = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	input  logic                        q_restart,
	input  logic signed [DataWidth-1:0] q_a,
	input  logic signed [DataWidth-1:0] q_d,
	input  logic [AngleBits-1:0]        q_twist,
	input  logic [AngleBits-1:0]        q_theta,
	output logic                        pop,
	dhfk_frame_if.source                res
);
	import dhfk_pkg::*;

	localparam int CW = FracBits + 2;
	localparam int PW = CW + DataWidth + 2;
	localparam logic signed [CW-1:0] One = CW'(1) <<< FracBits;

	be_state_t state_q, state_d;

	logic signed [CW-1:0] rot_q [9];
	logic signed [CW-1:0] nrot_q [9];
	logic signed [DataWidth-1:0] pos_q [3];
	logic signed [DataWidth-1:0] npos_q [3];
	logic signed [CW-1:0] lr_q [9];
	logic signed [DataWidth-1:0] lp_q [3];
	logic signed [CW-1:0] sth_q, cth_q;
	logic signed [DataWidth+1:0] acc_q;
	logic [1:0] ang_q;
	logic [3:0] step_q;
	logic [1:0] k_q;
	logic [3:0] ent_q;

	logic cstart, cdone;
	logic signed [CW-1:0] csin, ccos;
	logic signed [CW-1:0] m_coef;
	logic signed [DataWidth-1:0] m_val;
	logic signed [PW-1:0] m_prod;
	logic signed [DataWidth+1:0] m_res;

	// Theta starts from idle, twist starts once theta is done.
	dhfk_cordic #(.AngleBits(AngleBits), .FracBits(FracBits)) u_cordic (
		.clk, .arst_n, .start(cstart),
		.angle(state_q == ST_IDLE ? q_theta : q_twist),
		.done(cdone), .sin_o(csin), .cos_o(ccos)
	);

	function automatic logic signed [DataWidth-1:0] sat_dw(
		input logic signed [DataWidth+1:0] v);
		logic signed [DataWidth+1:0] hi, lo;
		hi = (DataWidth+2)'((64'sd1 <<< (DataWidth - 1)) - 64'sd1);
		lo = -hi - 1;
		if (v > hi) return hi[DataWidth-1:0];
		if (v < lo) return lo[DataWidth-1:0];
		return v[DataWidth-1:0];
	endfunction

	function automatic logic signed [CW-1:0] clamp1(input logic signed [DataWidth+1:0] v);
		if (v > (DataWidth+2)'(One)) return One;
		if (v < -(DataWidth+2)'(One)) return -One;
		return v[CW-1:0];
	endfunction

	// Select multiplier operands for the current step.
	// LINK steps: 0 cal*sth, 1 cal*cth, 2 sal*sth, 3 sal*cth, 4 sal*d, 5 cal*d.
	// MAT: entry e (0..11), term k; rows i=e/4, col j=e%4 (3 = position).
	logic [1:0] ei, ej;
	assign ei = ent_q[3:2];
	assign ej = ent_q[1:0];
	always_comb begin
		m_coef = '0;
		m_val  = '0;
		if (state_q == ST_LINK) begin
			unique case (step_q)
				4'd0: begin m_coef = lr_q[8]; m_val = DataWidth'(sth_q); end
				4'd1: begin m_coef = lr_q[8]; m_val = DataWidth'(cth_q); end
				4'd2: begin m_coef = -lr_q[5]; m_val = DataWidth'(sth_q); end
				4'd3: begin m_coef = -lr_q[5]; m_val = DataWidth'(cth_q); end
				4'd4: begin m_coef = -lr_q[5]; m_val = q_d; end
				default: begin m_coef = lr_q[8]; m_val = q_d; end
			endcase
		end else begin
			m_coef = rot_q[4'(ei) * 4'd3 + 4'(k_q)];
			if (ej == 2'd3) m_val = lp_q[k_q];
			else m_val = DataWidth'(lr_q[4'(k_q) * 4'd3 + 4'(ej)]);
		end
	end

	// Exact half-up rounded product.
	assign m_prod = PW'(m_coef) * PW'(m_val);
	assign m_res  = (DataWidth+2)'((m_prod + (PW'(1) <<< (FracBits - 1))) >>> FracBits);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (q_valid) state_d = ST_CORDIC;
			ST_CORDIC: if (cdone && ang_q == 2'd1) state_d = ST_LINK;
			ST_LINK: if (step_q == 4'd5) state_d = ST_MAT;
			ST_MAT: if (k_q == 2'd2 && ent_q == 4'd11) state_d = ST_OUT;
			ST_OUT: if (res.ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		cstart = (state_q == ST_IDLE && q_valid) || (state_q == ST_CORDIC && cdone &&
			ang_q == 2'd0);
		pop = (state_q == ST_OUT) && res.ready;
		res.valid = (state_q == ST_OUT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ang_q   <= '0;
			step_q  <= '0;
			k_q     <= '0;
			ent_q   <= '0;
			for (int i = 0; i < 9; i++) rot_q[i] <= (i % 4 == 0) ? One : '0;
			for (int i = 0; i < 3; i++) pos_q[i] <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					ang_q <= '0;
					if (q_valid && q_restart) begin
						for (int i = 0; i < 9; i++) rot_q[i] <= (i % 4 == 0) ? One : '0;
						for (int i = 0; i < 3; i++) pos_q[i] <= '0;
					end
				end
				ST_CORDIC: if (cdone) ang_q <= ang_q + 2'd1;
				ST_LINK: begin
					step_q <= (step_q == 4'd5) ? 4'd0 : step_q + 4'd1;
					k_q <= '0;
					ent_q <= '0;
				end
				ST_MAT: begin
					if (k_q == 2'd2) begin
						k_q <= '0;
						ent_q <= ent_q + 4'd1;
					end else begin
						k_q <= k_q + 2'd1;
					end
				end
				ST_OUT: if (res.ready) begin
					for (int i = 0; i < 9; i++) rot_q[i] <= nrot_q[i];
					for (int i = 0; i < 3; i++) pos_q[i] <= npos_q[i];
				end
				default: ;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_CORDIC && cdone) begin
			if (ang_q == 2'd0) begin
				sth_q <= csin; cth_q <= ccos;
			end else begin
				lr_q[0] <= cth_q; lr_q[1] <= -sth_q; lr_q[2] <= '0;
				lr_q[5] <= -csin; lr_q[8] <= ccos;
				lp_q[0] <= q_a;
			end
		end
		if (state_q == ST_LINK) begin
			unique case (step_q)
				4'd0: lr_q[3] <= m_res[CW-1:0];
				4'd1: lr_q[4] <= m_res[CW-1:0];
				4'd2: lr_q[6] <= m_res[CW-1:0];
				4'd3: lr_q[7] <= m_res[CW-1:0];
				4'd4: lp_q[1] <= sat_dw(-m_res);
				default: lp_q[2] <= sat_dw(m_res);
			endcase
		end
		if (state_q == ST_MAT) begin
			logic signed [DataWidth+1:0] base, sum;
			base = (ej == 2'd3) ? (DataWidth+2)'(pos_q[ei]) : '0;
			sum  = ((k_q == 2'd0) ? base : acc_q) + m_res;
			acc_q <= sum;
			if (k_q == 2'd2) begin
				if (ej == 2'd3) npos_q[ei] <= sat_dw(sum);
				else nrot_q[4'(ei) * 4'd3 + 4'(ej)] <= clamp1(sum);
			end
		end
	end

	assign res.rot_00 = 18'(nrot_q[0]); assign res.rot_01 = 18'(nrot_q[1]);
	assign res.rot_02 = 18'(nrot_q[2]); assign res.rot_10 = 18'(nrot_q[3]);
	assign res.rot_11 = 18'(nrot_q[4]); assign res.rot_12 = 18'(nrot_q[5]);
	assign res.rot_20 = 18'(nrot_q[6]); assign res.rot_21 = 18'(nrot_q[7]);
	assign res.rot_22 = 18'(nrot_q[8]);
	assign res.pos_x  = 32'(npos_q[0]);
	assign res.pos_y  = 32'(npos_q[1]);
	assign res.pos_z  = 32'(npos_q[2]);
endmodule

[hw/rtl/dhfk_checker.sv]
// Port-level checks for the forward kinematics unit, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module dhfk_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [17:0] r00,
	input logic [17:0] r22
);
	`ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result dropped")
	`ASSERT_NEXT(a_stable, clk, arst_n, out_valid && !out_ready, $stable(r00), "r00 moved")
	`ASSERT_IMP(a_unit, clk, arst_n, out_valid,
		($signed(r00) <= 18'sd65536) && ($signed(r22) >= -18'sd65536), "rotation out of range")
endmodule

bind dh_chain_forward_kinematics_unit dhfk_checker u_chk (
	.clk, .arst_n, .out_valid(frame.valid), .out_ready(frame.ready),
	.r00(frame.rot_00), .r22(frame.rot_22)
);
